### rtl/core/krle_pkg.sv
// ----------------------------------------------------------------------------
// krle_pkg
// Shared types and codes for the keyed record list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package krle_pkg;
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_LIST   = 3'd3;
    localparam logic [2:0] OP_DATE   = 3'd4;
    localparam logic [2:0] OP_PRIO   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOTF  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [2:0] PRIO_TOP = 3'd5;
    localparam logic [2:0] PRIO_BOT = 3'd1;
    localparam int unsigned RESULT_CAP = 32;

    typedef struct packed {
        logic [15:0] id;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  prio;
    } t_rec;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic rd;         // read store at index
        logic wr_append;  // write query at count
        logic shift_wr;   // write shifted record at index-1
        logic cnt_inc;
        logic cnt_dec;
    } t_cmd;
endpackage
`default_nettype wire

### rtl/core/keyed_record_list_engine_unit.sv
// ----------------------------------------------------------------------------
// keyed_record_list_engine_unit
// Insertion-ordered record table with find, remove and three listings.
// ----------------------------------------------------------------------------
// Append: query registered on accept, result from dispatch. Find/list: read and
// test per record walked plus an emit per result word. Remove: walk plus a shift
// per moved record. Priority listing walks the table once per level 5..1.
// One word at a time; stall is high from accept until the final result is
// registered. Synchronous reset clears the count; store contents are undefined.
`default_nettype none
module keyed_record_list_engine_unit import krle_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_rec_id,
    input  wire logic [11:0] i_year,
    input  wire logic [3:0]  i_month,
    input  wire logic [4:0]  i_day,
    input  wire logic [2:0]  i_priority_req,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [15:0]      o_out_id,
    output logic [11:0]      o_out_year,
    output logic [3:0]       o_out_month,
    output logic [4:0]       o_out_day,
    output logic [2:0]       o_out_priority,
    output logic [5:0]       o_entry_count,
    output logic             o_last
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cmd w_cmd;
    t_rec w_in, w_q, w_rd, w_orec;
    logic [IW-1:0] w_ri, w_wi;
    logic [CW-1:0] w_cnt, w_ocnt;

    assign w_in = '{id: i_rec_id, year: i_year, month: i_month, day: i_day,
                    prio: i_priority_req};

    krle_datapath #(.DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_rd_idx(w_ri), .i_wr_idx(w_wi),
        .i_rec(w_in), .o_query(w_q), .o_rd_rec(w_rd), .o_count(w_cnt));

    krle_ctrl #(.DEPTH(TABLE_DEPTH), .IW(IW), .CW(CW)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_query(w_q),
        .i_rd_rec(w_rd), .i_count(w_cnt), .o_cmd(w_cmd), .o_rd_idx(w_ri),
        .o_wr_idx(w_wi), .o_valid, .i_stall, .o_status, .o_rec(w_orec),
        .o_entry_count(w_ocnt), .o_last);

    assign o_out_id = w_orec.id;
    assign o_out_year = w_orec.year;
    assign o_out_month = w_orec.month;
    assign o_out_day = w_orec.day;
    assign o_out_priority = w_orec.prio;
    assign o_entry_count = 6'(w_ocnt);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_last))
        else $error("held result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CW'(TABLE_DEPTH)) else $error("count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.cnt_inc && w_cmd.cnt_dec)) else $error("count conflict");
endmodule
`default_nettype wire

### rtl/core/krle_datapath.sv
// ----------------------------------------------------------------------------
// krle_datapath
// Record store memory, record count and query register.
// ----------------------------------------------------------------------------
`default_nettype none
module krle_datapath import krle_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int IW = 5,
    parameter int CW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    input  wire logic [IW-1:0] i_rd_idx,
    input  wire logic [IW-1:0] i_wr_idx,
    input  wire t_rec          i_rec,
    output t_rec               o_query,
    output t_rec               o_rd_rec,
    output logic [CW-1:0]      o_count
);
    t_rec r_mem [DEPTH];
    t_rec r_q;
    t_rec r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_q <= i_rec;
        if (i_cmd.rd) r_rd <= r_mem[i_rd_idx];
        if (i_cmd.wr_append) r_mem[r_cnt[IW-1:0]] <= r_q;
        else if (i_cmd.shift_wr) r_mem[i_wr_idx] <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (i_cmd.cnt_inc) r_cnt <= r_cnt + 1'b1;
        else if (i_cmd.cnt_dec) r_cnt <= r_cnt - 1'b1;
    end

    assign o_query  = r_q;
    assign o_rd_rec = r_rd;
    assign o_count  = r_cnt;
endmodule
`default_nettype wire

### rtl/core/krle_ctrl.sv
// ----------------------------------------------------------------------------
// krle_ctrl
// Sequencer: walks the store for each opcode and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module krle_ctrl import krle_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int IW = 5,
    parameter int CW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [2:0]    i_opcode,
    input  wire t_rec          i_query,
    input  wire t_rec          i_rd_rec,
    input  wire logic [CW-1:0] i_count,
    output t_cmd               o_cmd,
    output logic [IW-1:0]      o_rd_idx,
    output logic [IW-1:0]      o_wr_idx,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [1:0]         o_status,
    output t_rec               o_rec,
    output logic [CW-1:0]      o_entry_count,
    output logic               o_last
);
    typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_READ, S_TEST, S_SHIFT, S_EMIT, S_FINAL}
        t_state;

    t_state r_state;
    logic [2:0] r_op;
    logic [CW:0] r_i;      // walk position (counts up, or down for priority)
    logic [2:0] r_p;
    logic [CW:0] r_n;      // records found
    logic r_hit;
    t_rec r_prec;          // found record not yet sent
    logic r_ov;
    logic [1:0] r_st;
    t_rec r_orec;
    logic [CW-1:0] r_ocnt;
    logic r_olast;
    logic r_shifting;

    logic [CW:0] w_cnt;
    logic w_date_ok;
    logic w_match;
    logic w_out_free;
    logic w_emit;
    logic [1:0] w_fin_st;

    assign w_cnt = {1'b0, i_count};
    assign w_out_free = !r_ov || !i_stall;

    always_comb begin
        if (i_rd_rec.year != i_query.year) w_date_ok = i_rd_rec.year > i_query.year;
        else if (i_rd_rec.month != i_query.month) w_date_ok = i_rd_rec.month > i_query.month;
        else w_date_ok = i_rd_rec.day >= i_query.day;
    end

    always_comb begin
        unique case (r_op)
            OP_FIND, OP_REMOVE: w_match = i_rd_rec.id == i_query.id;
            OP_LIST:            w_match = 1'b1;
            OP_DATE:            w_match = w_date_ok;
            OP_PRIO:            w_match = i_rd_rec.prio == r_p;
            default:            w_match = 1'b0;
        endcase
    end

    // status of the closing word
    always_comb begin
        if (r_hit) w_fin_st = ST_OK;
        else if (r_op == OP_FIND || r_op == OP_REMOVE) w_fin_st = ST_NOTF;
        else if (r_op == OP_LIST || r_op == OP_DATE || r_op == OP_PRIO) w_fin_st = ST_EMPTY;
        else w_fin_st = ST_OK;
    end

    // walk position in store index terms; priority walks downward, index = r_i-1
    // shift writes land two behind the read position
    always_comb begin
        o_rd_idx = (r_op == OP_PRIO) ? IW'(r_i - 1'b1) : IW'(r_i);
        o_wr_idx = IW'(r_i - 2'd2);
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.rd = (r_state == S_READ) || (r_state == S_SHIFT && r_i < w_cnt);
        o_cmd.shift_wr = (r_state == S_SHIFT) && r_shifting;
        o_cmd.wr_append = (r_state == S_DISPATCH) && (r_op == OP_APPEND)
                          && (w_cnt < (CW+1)'(DEPTH)) && w_out_free;
        o_cmd.cnt_inc = o_cmd.wr_append;
        o_cmd.cnt_dec = (r_state == S_SHIFT) && !(r_i < w_cnt);
    end

    assign w_emit = w_out_free && (((r_state == S_DISPATCH) && (r_op == OP_APPEND))
                                   || ((r_state == S_EMIT) && r_hit)
                                   || (r_state == S_FINAL));

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_rec = r_orec;
    assign o_entry_count = r_ocnt;
    assign o_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (w_emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op <= i_opcode;
                    r_n <= '0;
                    r_p <= PRIO_TOP;
                    r_hit <= 1'b0;
                    r_shifting <= 1'b0;
                    r_state <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    r_i <= (r_op == OP_PRIO) ? w_cnt : '0;
                    if (r_op == OP_APPEND) begin
                        if (w_out_free) begin
                            r_olast <= 1'b1;
                            r_ocnt <= o_cmd.wr_append ? i_count + 1'b1 : i_count;
                            r_st <= o_cmd.wr_append ? ST_OK : ST_FULL;
                            r_orec <= o_cmd.wr_append ? i_query : '0;
                            r_state <= S_IDLE;
                        end
                    end else if (r_op > OP_PRIO) begin
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // end-of-walk check while the read of the current entry is issued
                    if (r_op == OP_PRIO) begin
                        if (r_n == (CW+1)'(RESULT_CAP)) r_state <= S_FINAL;
                        else if (r_i == '0) begin
                            if (r_p == PRIO_BOT) r_state <= S_FINAL;
                            else begin
                                r_p <= r_p - 1'b1;
                                r_i <= w_cnt;
                            end
                        end else r_state <= S_TEST;
                    end else if (r_i >= w_cnt || r_n == (CW+1)'(RESULT_CAP))
                        r_state <= S_FINAL;
                    else r_state <= S_TEST;
                end
                S_TEST: begin
                    if (w_match && (r_op == OP_FIND || r_op == OP_REMOVE)) begin
                        r_hit <= 1'b1;
                        r_prec <= i_rd_rec;
                        if (r_op == OP_REMOVE) begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_SHIFT;
                        end else r_state <= S_FINAL;
                    end else if (w_match) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_i <= (r_op == OP_PRIO) ? r_i - 1'b1 : r_i + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SHIFT: begin
                    // read entry r_i, then write it to r_i-1 next cycle
                    if (r_i < w_cnt) begin
                        r_shifting <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_shifting <= 1'b0;
                        r_state <= S_FINAL;
                    end
                end
                // a match is held back one step so the closing word can carry last
                S_EMIT: if (w_out_free || !r_hit) begin
                    if (r_hit) begin
                        r_olast <= 1'b0;
                        r_st <= ST_OK;
                        r_orec <= r_prec;
                        r_ocnt <= i_count;
                    end
                    r_prec <= i_rd_rec;
                    r_n <= r_n + 1'b1;
                    r_hit <= 1'b1;
                    r_i <= (r_op == OP_PRIO) ? r_i - 1'b1 : r_i + 1'b1;
                    r_state <= S_READ;
                end
                S_FINAL: if (w_out_free) begin
                    r_olast <= 1'b1;
                    r_st <= w_fin_st;
                    r_orec <= r_hit ? r_prec : '0;
                    r_ocnt <= i_count;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
